// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/wsfd_pkg.sv =====
// Types and constants of the WebSocket frame deframer.
package wsfd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_TRUNC   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [3:0]  frame_opcode;
      logic        final_flag;
      logic        was_masked;
      logic [63:0] payload_length;
      logic [63:0] frame_length;
      logic        last_of_frame;
   } result_type;

   localparam logic [6:0] LEN7_EXT16   = 7'd126;
   localparam logic [6:0] LEN7_EXT64   = 7'd127;
   localparam logic [3:0] HDR_LEN_BASE = 4'd2;
   localparam logic [3:0] EXT16_BYTES  = 4'd2;
   localparam logic [3:0] EXT64_BYTES  = 4'd8;
   localparam logic [3:0] KEY_BYTES    = 4'd4;

endpackage

// ===== rtl/wsfd_parse.sv =====
// Frame header parser and payload unmasking, one byte per accepted item.
`include "assert_macros.svh"
module wsfd_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               stream_closed,
   output logic               res_valid,
   output wsfd_pkg::result_type res_item
);
   import wsfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [63:0] len_ff, len_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] key_ff, key_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;
   logic        mask_ff, mask_in;
   logic [1:0]  idx_ff, idx_in;
   logic [63:0] rem_ff, rem_in;
   logic [3:0]  hlen_ff, hlen_in;

   logic [6:0]  len7;
   logic        is_ext;
   logic        cnt_last;
   logic        rem_last;
   logic [63:0] ext_len;
   logic [7:0]  key_byte;
   logic [64:0] flen_sum;
   logic [63:0] flen_sat;
   logic        res_last;
   kind_type    res_kind;
   logic [7:0]  res_byte;

   assign len7     = data_byte[6:0];
   assign is_ext   = (len7 == LEN7_EXT16) || (len7 == LEN7_EXT64);
   assign cnt_last = (cnt_ff == 4'd1);
   assign rem_last = (rem_ff == 64'd1);
   assign ext_len  = {len_ff[55:0], data_byte};

   always_comb begin
      unique case (idx_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         2'd3: key_byte = key_ff[7:0];
         default: key_byte = key_ff[31:24];
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (stream_closed) begin
            phase_in = PH_HDR0;
         end else begin
            unique case (phase_ff)
               PH_HDR0: phase_in = PH_HDR1;
               PH_HDR1: begin
                  if (is_ext)
                     phase_in = PH_EXTLEN;
                  else if (data_byte[7])
                     phase_in = PH_KEY;
                  else if (len7 == 7'd0)
                     phase_in = PH_HDR0;
                  else
                     phase_in = PH_PAYLOAD;
               end
               PH_EXTLEN: begin
                  if (!cnt_last)
                     phase_in = PH_EXTLEN;
                  else if (mask_ff)
                     phase_in = PH_KEY;
                  else if (ext_len == 64'd0)
                     phase_in = PH_HDR0;
                  else
                     phase_in = PH_PAYLOAD;
               end
               PH_KEY: begin
                  if (!cnt_last)
                     phase_in = PH_KEY;
                  else if (len_ff == 64'd0)
                     phase_in = PH_HDR0;
                  else
                     phase_in = PH_PAYLOAD;
               end
               PH_PAYLOAD: phase_in = rem_last ? PH_HDR0 : PH_PAYLOAD;
               default: phase_in = PH_HDR0;
            endcase
         end
      end
   end

   // datapath and result
   always_comb begin
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      mask_in   = mask_ff;
      idx_in    = idx_ff;
      rem_in    = rem_ff;
      hlen_in   = hlen_ff;
      res_valid = 1'b0;
      res_kind  = KIND_PAYLOAD;
      res_byte  = 8'd0;
      res_last  = 1'b0;
      if (accept) begin
         if (stream_closed) begin
            if (phase_ff != PH_HDR0) begin
               res_valid = 1'b1;
               res_kind  = KIND_TRUNC;
            end
         end else begin
            unique case (phase_ff)
               PH_HDR0: begin
                  fin_in    = data_byte[7];
                  opcode_in = data_byte[3:0];
                  mask_in   = 1'b0;
                  key_in    = 32'd0;
                  len_in    = 64'd0;
                  idx_in    = 2'd0;
                  cnt_in    = 4'd0;
                  hlen_in   = HDR_LEN_BASE;
               end
               PH_HDR1: begin
                  mask_in = data_byte[7];
                  if (is_ext) begin
                     cnt_in  = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                     hlen_in = HDR_LEN_BASE + cnt_in;
                     len_in  = 64'd0;
                  end else begin
                     len_in = {57'd0, len7};
                     if (data_byte[7]) begin
                        cnt_in  = KEY_BYTES;
                        hlen_in = hlen_ff + KEY_BYTES;
                     end else begin
                        idx_in = 2'd0;
                        rem_in = {57'd0, len7};
                        if (len7 == 7'd0) begin
                           res_valid = 1'b1;
                           res_kind  = KIND_EMPTY;
                           res_last  = 1'b1;
                        end
                     end
                  end
               end
               PH_EXTLEN: begin
                  len_in = ext_len;
                  cnt_in = cnt_ff - 4'd1;
                  if (cnt_last) begin
                     if (mask_ff) begin
                        cnt_in  = KEY_BYTES;
                        hlen_in = hlen_ff + KEY_BYTES;
                     end else begin
                        idx_in = 2'd0;
                        rem_in = ext_len;
                        if (ext_len == 64'd0) begin
                           res_valid = 1'b1;
                           res_kind  = KIND_EMPTY;
                           res_last  = 1'b1;
                        end
                     end
                  end
               end
               PH_KEY: begin
                  key_in = {key_ff[23:0], data_byte};
                  cnt_in = cnt_ff - 4'd1;
                  if (cnt_last) begin
                     idx_in = 2'd0;
                     rem_in = len_ff;
                     if (len_ff == 64'd0) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_EMPTY;
                        res_last  = 1'b1;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  res_valid = 1'b1;
                  res_kind  = KIND_PAYLOAD;
                  res_byte  = data_byte ^ key_byte;
                  res_last  = rem_last;
                  idx_in    = idx_ff + 2'd1;
                  rem_in    = rem_ff - 64'd1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign flen_sum = {1'b0, len_in} + {61'd0, hlen_ff};
   assign flen_sat = flen_sum[64] ? {64{1'b1}} : flen_sum[63:0];

   always_comb begin
      res_item.kind           = res_kind;
      res_item.payload_byte   = res_byte;
      res_item.frame_opcode   = opcode_in;
      res_item.final_flag     = fin_in;
      res_item.was_masked     = mask_in;
      res_item.payload_length = len_in;
      res_item.frame_length   = res_last ? flen_sat : 64'd0;
      res_item.last_of_frame  = res_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         key_ff    <= key_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         mask_ff   <= mask_in;
         idx_ff    <= idx_in;
         rem_ff    <= rem_in;
         hlen_ff   <= hlen_in;
      end
   end

   `ASSERT_PROP(a_payload_rem_nonzero, clock, reset, phase_ff == PH_PAYLOAD |-> rem_ff != 64'd0)
   `ASSERT_PROP(a_empty_is_last, clock, reset, res_valid && res_item.kind == KIND_EMPTY |-> res_item.last_of_frame && res_item.frame_length >= 64'd2)
   `ASSERT_PROP(a_trunc_not_last, clock, reset, res_valid && res_item.kind == KIND_TRUNC |-> !res_item.last_of_frame && res_item.frame_length == 64'd0)

endmodule

// ===== rtl/wsfd_skid.sv =====
// Two-entry result buffer: output register plus skid register.
`include "assert_macros.svh"
module wsfd_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  wsfd_pkg::result_type in_item,
   output logic                 full,
   output logic                 out_valid,
   output wsfd_pkg::result_type out_item,
   input  logic                 out_stall
);
   import wsfd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_item_ff, out_item_in;
   result_type skid_item_ff, skid_item_in;
   logic       out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = in_valid;
            skid_item_in  = in_item;
         end else begin
            out_valid_in = in_valid;
            out_item_in  = in_item;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   `ASSERT_PROP(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff)
   `ASSERT_NEVER(a_no_overflow, clock, reset, in_valid && skid_valid_ff)

endmodule

// ===== rtl/websocket_frame_deframer_unit.sv =====
// Top level of the WebSocket frame deframer.
//
// Request channel (req_*): one stream byte per item, or a close marker when
// req_stream_closed is high (the data byte is then ignored). An item is taken
// at a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): zero or one result per request item: an unmasked
// payload byte, an empty-frame marker, or a truncated-frame error when the
// stream closes inside a frame. rsp_frame_length is set only on the result
// that closes a frame.
// A result is registered before it shows on rsp_valid.
// Throughput: one byte per cycle while req_stall is low; the header parse,
// unmasking and length arithmetic all finish between the parser state and the output register.
// A skid register behind the output register holds one more result after
// rsp_stall rises; items that yield no result are still taken meanwhile.
// req_stall follows from the skid register and is high only while both
// registers hold a result.
// Reset (synchronous, active high) empties both registers and returns the
// parser to waiting for the first header byte of a frame.
module websocket_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_closed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_final_flag,
   output logic        rsp_was_masked,
   output logic [63:0] rsp_payload_length,
   output logic [63:0] rsp_frame_length,
   output logic        rsp_last_of_frame
);
   import wsfd_pkg::*;

   logic       accept;
   logic       res_valid;
   result_type res_item;
   result_type out_item;
   logic       buf_full;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   wsfd_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .stream_closed (req_stream_closed),
      .res_valid     (res_valid),
      .res_item      (res_item)
   );

   wsfd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_item   (res_item),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_item  (out_item),
      .out_stall (rsp_stall)
   );

   assign rsp_kind           = out_item.kind;
   assign rsp_payload_byte   = out_item.payload_byte;
   assign rsp_frame_opcode   = out_item.frame_opcode;
   assign rsp_final_flag     = out_item.final_flag;
   assign rsp_was_masked     = out_item.was_masked;
   assign rsp_payload_length = out_item.payload_length;
   assign rsp_frame_length   = out_item.frame_length;
   assign rsp_last_of_frame  = out_item.last_of_frame;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the WebSocket frame deframer: directed and random byte streams.
module tb;
   import wsfd_pkg::*;

   localparam int ITEM_TARGET  = 1750;
   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_LINES = 60;

   // bit 8 marks a stream close
   localparam logic [8:0] OPENING [29] = '{
      9'h100,
      9'h000, 9'h000,
      9'h071, 9'h082, 9'h001, 9'h002, 9'h003, 9'h004, 9'h0FF, 9'h000,
      9'h08A, 9'h001, 9'h05A,
      9'h0FF, 9'h07E, 9'h000, 9'h000,
      9'h082, 9'h07F, 9'h080, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
      9'h1FF
   };

   class frame_checker;
      result_type  queued_results[$];
      int          errors;
      phase_type   phase;
      logic [63:0] len_acc;
      logic [3:0]  field_cnt;
      logic [31:0] key;
      logic [3:0]  opcode;
      logic        fin;
      logic        masked;
      logic [63:0] pay_idx;
      logic [3:0]  hdr_len;

      function new();
         errors    = 0;
         phase     = PH_HDR0;
         len_acc   = '0;
         field_cnt = '0;
         key       = '0;
         opcode    = '0;
         fin       = 1'b0;
         masked    = 1'b0;
         pay_idx   = '0;
         hdr_len   = HDR_LEN_BASE;
      endfunction

      function result_type emit(kind_type k, logic [7:0] b, logic is_last);
         result_type  r;
         logic [64:0] total;
         total            = {1'b0, len_acc} + {61'd0, hdr_len};
         r.kind           = k;
         r.payload_byte   = b;
         r.frame_opcode   = opcode;
         r.final_flag     = fin;
         r.was_masked     = masked;
         r.payload_length = len_acc;
         r.frame_length   = !is_last ? 64'd0 : (total[64] ? '1 : total[63:0]);
         r.last_of_frame  = is_last;
         return r;
      endfunction

      function void open_payload();
         pay_idx = '0;
         if (len_acc == 64'd0) begin
            queued_results.push_back(emit(KIND_EMPTY, 8'h00, 1'b1));
            phase = PH_HDR0;
         end else begin
            phase = PH_PAYLOAD;
         end
      endfunction

      function void length_done();
         if (masked) begin
            phase     = PH_KEY;
            field_cnt = KEY_BYTES;
            hdr_len   = hdr_len + KEY_BYTES;
         end else begin
            open_payload();
         end
      endfunction

      function void take_byte(logic [7:0] b, logic closed);
         logic [6:0] len7;
         logic [7:0] key_byte;
         logic       is_last;
         if (closed) begin
            if (phase != PH_HDR0) begin
               queued_results.push_back(emit(KIND_TRUNC, 8'h00, 1'b0));
               phase = PH_HDR0;
            end
            return;
         end
         case (phase)
            PH_HDR0: begin
               fin       = b[7];
               opcode    = b[3:0];
               masked    = 1'b0;
               key       = '0;
               len_acc   = '0;
               pay_idx   = '0;
               field_cnt = '0;
               hdr_len   = HDR_LEN_BASE;
               phase     = PH_HDR1;
            end
            PH_HDR1: begin
               len7   = b[6:0];
               masked = b[7];
               if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
                  field_cnt = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  hdr_len   = HDR_LEN_BASE + field_cnt;
                  len_acc   = '0;
                  phase     = PH_EXTLEN;
               end else begin
                  len_acc = {57'd0, len7};
                  length_done();
               end
            end
            PH_EXTLEN: begin
               len_acc   = {len_acc[55:0], b};
               field_cnt = field_cnt - 4'd1;
               if (field_cnt == 4'd0)
                  length_done();
            end
            PH_KEY: begin
               key       = {key[23:0], b};
               field_cnt = field_cnt - 4'd1;
               if (field_cnt == 4'd0)
                  open_payload();
            end
            PH_PAYLOAD: begin
               key_byte = key[8 * (3 - int'(pay_idx[1:0])) +: 8];
               is_last  = (pay_idx + 64'd1 == len_acc);
               queued_results.push_back(emit(KIND_PAYLOAD, b ^ key_byte, is_last));
               pay_idx = pay_idx + 64'd1;
               if (is_last)
                  phase = PH_HDR0;
            end
            default: phase = PH_HDR0;
         endcase
      endfunction

      task report(string msg);
         if (errors < REPORT_LINES)
            $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task match_result(result_type got);
         result_type want;
         if (queued_results.size() == 0) begin
            report($sformatf("unexpected result, kind %0d", got.kind));
            return;
         end
         want = queued_results.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, want %0d", got.kind, want.kind));
         if (got.payload_byte !== want.payload_byte)
            report($sformatf("payload_byte %0h, want %0h", got.payload_byte, want.payload_byte));
         if (got.frame_opcode !== want.frame_opcode)
            report($sformatf("frame_opcode %0h, want %0h", got.frame_opcode, want.frame_opcode));
         if (got.final_flag !== want.final_flag)
            report($sformatf("final_flag %0b, want %0b", got.final_flag, want.final_flag));
         if (got.was_masked !== want.was_masked)
            report($sformatf("was_masked %0b, want %0b", got.was_masked, want.was_masked));
         if (got.payload_length !== want.payload_length)
            report($sformatf("payload_length %0h, want %0h",
                             got.payload_length, want.payload_length));
         if (got.frame_length !== want.frame_length)
            report($sformatf("frame_length %0h, want %0h", got.frame_length, want.frame_length));
         if (got.last_of_frame !== want.last_of_frame)
            report($sformatf("last_of_frame %0b, want %0b",
                             got.last_of_frame, want.last_of_frame));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_stream_closed;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_final_flag;
   logic        rsp_was_masked;
   logic [63:0] rsp_payload_length;
   logic [63:0] rsp_frame_length;
   logic        rsp_last_of_frame;

   frame_checker sb = new();
   int items_sent   = 0;
   int req_gap_pct  = 0;
   int rsp_hold_pct = 0;
   int long_hold    = 0;

   websocket_frame_deframer_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_stream_closed  (req_stream_closed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_flag     (rsp_final_flag),
      .rsp_was_masked     (rsp_was_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_item(logic [7:0] data, logic closed);
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_stream_closed <= closed;
      do @(posedge clock); while (req_stall);
      sb.take_byte(data, closed);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.queued_results.size() != 0) @(posedge clock);
   endtask

   // chop: the frame is cut short by a close
   task automatic play_frame(bit chop);
      logic [7:0]  wire_bytes[$];
      logic [63:0] plen;
      logic        msk;
      int          mode;
      int          body;
      int          cut;
      msk  = 1'($urandom_range(0, 1));
      mode = $urandom_range(0, 9);
      wire_bytes.push_back(8'($urandom_range(0, 255)));
      if (mode <= 5)
         plen = 64'($urandom_range(0, 12));
      else if (mode == 6)
         plen = 64'($urandom_range(0, 125));
      else if (mode <= 8)
         plen = chop ? 64'($urandom_range(0, 65535)) : 64'($urandom_range(0, 24));
      else
         plen = chop ? {$urandom, $urandom} : 64'($urandom_range(0, 24));
      if (mode <= 6) begin
         wire_bytes.push_back({msk, plen[6:0]});
      end else if (mode <= 8) begin
         wire_bytes.push_back({msk, LEN7_EXT16});
         wire_bytes.push_back(plen[15:8]);
         wire_bytes.push_back(plen[7:0]);
      end else begin
         wire_bytes.push_back({msk, LEN7_EXT64});
         for (int i = 7; i >= 0; i--)
            wire_bytes.push_back(plen[8 * i +: 8]);
      end
      if (msk)
         repeat (4) wire_bytes.push_back(8'($urandom_range(0, 255)));
      body = chop ? $urandom_range(0, 6) : int'(plen);
      if (64'(body) > plen)
         body = int'(plen);
      repeat (body) wire_bytes.push_back(8'($urandom_range(0, 255)));
      cut = chop ? $urandom_range(1, wire_bytes.size()) : wire_bytes.size();
      for (int i = 0; i < cut; i++)
         send_item(wire_bytes[i], 1'b0);
      if (chop)
         send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_stall <= 1'b1;
            long_hold--;
         end else if (rsp_hold_pct != 0 && $urandom_range(0, 99) < rsp_hold_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.kind           = kind_type'(rsp_kind);
            got.payload_byte   = rsp_payload_byte;
            got.frame_opcode   = rsp_frame_opcode;
            got.final_flag     = rsp_final_flag;
            got.was_masked     = rsp_was_masked;
            got.payload_length = rsp_payload_length;
            got.frame_length   = rsp_frame_length;
            got.last_of_frame  = rsp_last_of_frame;
            sb.match_result(got);
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      int  next_switch;
      int  pick;
      bit  pressure_done;
      next_switch       = 0;
      pressure_done     = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = 8'h00;
      req_stream_closed = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_gap_pct  = 20;
      rsp_hold_pct = 20;
      foreach (OPENING[i])
         send_item(OPENING[i][7:0], OPENING[i][8]);

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= next_switch) begin
            next_switch = items_sent + 200;
            if (items_sent >= ITEM_TARGET - 250) begin
               req_gap_pct  = 0;
               rsp_hold_pct = 0;
            end else begin
               req_gap_pct  = 15 * $urandom_range(0, 2);
               rsp_hold_pct = 15 * $urandom_range(0, 2);
            end
         end
         if (!pressure_done && items_sent >= 700) begin
            // receiver holds off while a 40-byte frame streams in
            pressure_done = 1'b1;
            req_gap_pct   = 0;
            long_hold     = 60;
            send_item(8'h82, 1'b0);
            send_item(8'd40, 1'b0);
            repeat (40) send_item(8'($urandom_range(0, 255)), 1'b0);
            wait_drained();
         end
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            play_frame(1'b0);
         end else if (pick < 17) begin
            play_frame(1'b1);
         end else if (pick < 19) begin
            repeat ($urandom_range(1, 5)) send_item(8'($urandom_range(0, 255)), 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.queued_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
